// ----- hdl/boolean_matrix_multiply_assert.svh -----
// Assertion macros for the boolean matrix multiplier checker.
// Clock and reset are taken from the names clock and reset in scope.
`ifndef BOOLEAN_MATRIX_MULTIPLY_ASSERT_SVH
`define BOOLEAN_MATRIX_MULTIPLY_ASSERT_SVH

// consequent holds in the cycle after the antecedent, outside reset
`define BMM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

// consequent holds in the same cycle, checked during reset too
`define BMM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

`endif

// ----- hdl/bmm_pkg.sv -----
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared constants and types of the boolean matrix multiplier.
// ----------------------------------------------------------------------------
package bmm_pkg;

   localparam int ROW_W       = 32;
   localparam int STORE_DEPTH = 32;
   localparam int IDX_W       = 5;
   localparam int SIZE_W      = 6;
   localparam int MAX_SIZE    = 32;
   localparam int NUM_LANES   = 4;

   localparam logic KIND_FIRST  = 1'b0;
   localparam logic KIND_SECOND = 1'b1;

   // control from the sequencer to the merge stage
   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] row;
      logic             last;
   } bmm_merge_ctl_type;

endpackage

// ----- hdl/bmm_lane.sv -----
// ----------------------------------------------------------------------------
// bmm_lane
// One lane: ORs the second-matrix rows of its slice selected by the
// first-matrix row bits, result registered.
// ----------------------------------------------------------------------------
module bmm_lane #(
   parameter int LANE_ROWS = 8
) (
   input  logic                                    clock,
   input  logic                                    enable,
   input  logic [LANE_ROWS-1:0]                    select_bits,
   input  logic [LANE_ROWS-1:0][bmm_pkg::ROW_W-1:0] rows,
   output logic [bmm_pkg::ROW_W-1:0]               partial_ff
);
   import bmm_pkg::*;

   logic [ROW_W-1:0] partial_in;

   always_comb begin
      partial_in = '0;
      for (int j = 0; j < LANE_ROWS; j++) begin
         if (select_bits[j]) begin
            partial_in = partial_in | rows[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         partial_ff <= partial_in;
      end
   end

endmodule

// ----- hdl/bmm_merge.sv -----
// ----------------------------------------------------------------------------
// bmm_merge
// Merge stage: ORs the lane partials, masks unused columns and holds the
// product row in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module bmm_merge #(
   parameter int LANES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [LANES-1:0][bmm_pkg::ROW_W-1:0] lane_partials,
   input  logic [bmm_pkg::ROW_W-1:0]           column_mask,
   input  bmm_pkg::bmm_merge_ctl_type          ctl,
   output logic                                slot_free,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bmm_pkg::IDX_W-1:0]           rsp_result_row,
   output logic [bmm_pkg::ROW_W-1:0]           rsp_result_bits,
   output logic                                rsp_last
);
   import bmm_pkg::*;

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] row_ff;
   logic [ROW_W-1:0] bits_ff, bits_in;
   logic             last_ff;

   // the slot frees up at this edge if empty or being taken now
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      bits_in = '0;
      for (int l = 0; l < LANES; l++) begin
         bits_in = bits_in | lane_partials[l];
      end
      bits_in = bits_in & column_mask;
   end

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = ctl.load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && ctl.load) begin
         row_ff  <= ctl.row;
         bits_ff <= bits_in;
         last_ff <= ctl.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_row  = row_ff;
   assign rsp_result_bits = bits_ff;
   assign rsp_last        = last_ff;

endmodule

// ----- hdl/boolean_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// boolean_matrix_multiply
// Boolean product of two square bit matrices loaded row by row.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one row per transaction. kind selects the first or second
//    matrix; a second-matrix row with start_req set stores the row and then
//    starts the product. One row is taken per cycle while no product runs.
//  - rsp channel: rows 0 to size-1 of the product, the final one with
//    rsp_last. The product row is the OR of the lane partials across LANES
//    parallel lanes, each covering STORE_DEPTH/LANES second-matrix rows.
//  - Each product row passes the lane stage (ST_LANE), then the merge stage
//    (ST_MERGE) into the output register.
//  - req_stall is high while a burst is being computed.
//  - A stalled rsp holds its payload; the sequencer waits in the merge stage
//    until the output register frees up.
//  - csr_write_data sets matrix_size; it applies from the next product.
//  - Reset (synchronous) clears the sequencer and output valid and sets the
//    size to 32; the row stores are not cleared and must be written first.
// ----------------------------------------------------------------------------
module boolean_matrix_multiply #(
   parameter int LANES = bmm_pkg::NUM_LANES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic [bmm_pkg::IDX_W-1:0]   req_row_index,
   input  logic [bmm_pkg::ROW_W-1:0]   req_row_bits,
   input  logic                        req_start_req,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bmm_pkg::IDX_W-1:0]   rsp_result_row,
   output logic [bmm_pkg::ROW_W-1:0]   rsp_result_bits,
   output logic                        rsp_last,
   input  logic                        csr_write_enable,
   input  logic [bmm_pkg::SIZE_W-1:0]  csr_write_data
);
   import bmm_pkg::*;

   localparam int LANE_ROWS = STORE_DEPTH / LANES;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LANE  = 3'b010,
      ST_MERGE = 3'b100
   } bmm_state_type;

   bmm_state_type state_ff, state_in;

   logic [STORE_DEPTH-1:0][ROW_W-1:0] first_ff;
   logic [STORE_DEPTH-1:0][ROW_W-1:0] second_ff;

   logic [SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]  last_idx_ff, last_idx_in;
   logic [ROW_W-1:0]  mask_ff, mask_in;
   logic [IDX_W-1:0]  row_ff, row_in;

   logic              req_take, start_take;
   logic [ROW_W-1:0]  first_row;
   logic              slot_free;
   bmm_merge_ctl_type merge_ctl;

   logic [LANES-1:0][ROW_W-1:0] lane_partials;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign start_take = req_take && (req_kind == KIND_SECOND) && req_start_req;

   // size 0 acts as 1, anything above the maximum saturates
   always_comb begin
      logic [SIZE_W-1:0] s;
      s = size_ff;
      if (s == '0) begin
         s = SIZE_W'(1);
      end
      if (s > SIZE_W'(MAX_SIZE)) begin
         s = SIZE_W'(MAX_SIZE);
      end
      last_idx_in = IDX_W'(s - SIZE_W'(1));
      for (int j = 0; j < ROW_W; j++) begin
         mask_in[j] = (IDX_W'(j) <= last_idx_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(32);
      end else if (csr_write_enable) begin
         size_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (start_take) begin
         last_idx_ff <= last_idx_in;
         mask_ff     <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         if (req_kind == KIND_FIRST) begin
            first_ff[req_row_index] <= req_row_bits;
         end else begin
            second_ff[req_row_index] <= req_row_bits;
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      merge_ctl.load  = 1'b0;
      merge_ctl.row   = row_ff;
      merge_ctl.last  = (row_ff == last_idx_ff);
      case (state_ff)
         ST_IDLE: begin
            row_in = '0;
            if (start_take) begin
               state_in = ST_LANE;
            end
         end
         ST_LANE: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            merge_ctl.load = 1'b1;
            if (slot_free) begin
               if (merge_ctl.last) begin
                  state_in = ST_IDLE;
                  row_in   = '0;
               end else begin
                  state_in = ST_LANE;
                  row_in   = row_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            row_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

   assign first_row = first_ff[row_ff] & mask_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      bmm_lane #(
         .LANE_ROWS (LANE_ROWS)
      ) u_lane (
         .clock       (clock),
         .enable      (state_ff == ST_LANE),
         .select_bits (first_row[l*LANE_ROWS +: LANE_ROWS]),
         .rows        (second_ff[l*LANE_ROWS +: LANE_ROWS]),
         .partial_ff  (lane_partials[l])
      );
   end

   bmm_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .lane_partials   (lane_partials),
      .column_mask     (mask_ff),
      .ctl             (merge_ctl),
      .slot_free       (slot_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_row  (rsp_result_row),
      .rsp_result_bits (rsp_result_bits),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- hdl/bmm_checker.sv -----
// ----------------------------------------------------------------------------
// bmm_checker
// Port-level checks of the boolean matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`include "boolean_matrix_multiply_assert.svh"

module bmm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_kind,
   input logic                       req_start_req,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [bmm_pkg::IDX_W-1:0]  rsp_result_row,
   input logic [bmm_pkg::ROW_W-1:0]  rsp_result_bits,
   input logic                       rsp_last
);
   import bmm_pkg::*;

   logic start_seen, rsp_mid;

   assign start_seen = req_valid && !req_stall && (req_kind == KIND_SECOND) && req_start_req;
   assign rsp_mid    = rsp_valid && !rsp_stall && !rsp_last;

   `BMM_ASSERT_SAME(a_reset_quiet, $past(reset), rsp_valid !== 1'b1)
   `BMM_ASSERT_NEXT(a_start_busy, start_seen, req_stall)
   // a row before the last one means the burst is still being worked on
   `BMM_ASSERT_SAME(a_burst_busy, rsp_mid, req_stall)
   `BMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `BMM_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_result_bits) && $stable(rsp_result_row) && $stable(rsp_last))

endmodule

bind boolean_matrix_multiply bmm_checker u_bmm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_kind        (req_kind),
   .req_start_req   (req_start_req),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_row  (rsp_result_row),
   .rsp_result_bits (rsp_result_bits),
   .rsp_last        (rsp_last)
);
